FILE: sv/u8d_pkg.sv
// ============================================================================
// u8d_pkg
// Types and constants shared by the UTF-8 to 16-bit code unit decoder.
// ============================================================================
`default_nettype none

package u8d_pkg;

    localparam logic [15:0] C_REPL       = 16'h005F;
    localparam logic [1:0]  C_HELD_NONE  = 2'd0;
    localparam logic [1:0]  C_HELD_LEAD  = 2'd1;
    localparam logic [1:0]  C_HELD_TWO   = 2'd2;
    localparam logic [2:0]  C_SKIP_F0    = 3'd3;
    localparam logic [2:0]  C_SKIP_F8    = 3'd4;
    localparam logic [2:0]  C_SKIP_FC    = 3'd5;
    localparam logic [2:0]  C_SKIP_NONE  = 3'd0;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       final_byte;
    } t_in;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        replaced;
        logic        run_end;
        logic        string_done;
    } t_res;

    typedef struct packed {
        logic [7:0] held_lead;
        logic [7:0] held_second;
        logic [1:0] held_count;
        logic [2:0] skip_left;
    } t_state;

    // results of one decode step, compacted to the front
    typedef struct packed {
        logic [1:0] num;
        t_res       res0;
        t_res       res1;
    } t_step;

endpackage

`default_nettype wire

FILE: sv/u8d_decode.sv
// ============================================================================
// u8d_decode
// Single step of the decoder: current state and one byte in, up to two
// result words and the next state out. Purely combinational.
// ============================================================================
`default_nettype none

module u8d_decode
    import u8d_pkg::*;
(
    input  var t_state i_state,
    input  var t_in    i_item,
    output var t_state o_state,
    output var t_step  o_step
);

    logic [7:0]  b;
    logic        cont;
    logic        do_start;
    logic        pre_v;
    logic [15:0] pre_cu;
    logic        pre_rep;
    logic        st_v;
    logic [15:0] st_cu;
    logic        st_rep;
    logic        fin_v;
    t_state      mid;
    t_res        r0;
    t_res        r1;
    logic [1:0]  num;
    logic        surrogate;
    logic        overlong;

    assign b    = i_item.byte_in;
    assign cont = (b[7:6] == 2'b10);

    assign surrogate = (i_state.held_lead[3:0] == 4'hD) && i_state.held_second[5];
    assign overlong  = (i_state.held_lead == 8'hE0) && (i_state.held_second[7:5] == 3'b100);

    always_comb begin
        mid      = i_state;
        do_start = 1'b0;
        pre_v    = 1'b0;
        pre_cu   = C_REPL;
        pre_rep  = 1'b1;
        st_v     = 1'b0;
        st_cu    = C_REPL;
        st_rep   = 1'b1;

        if (i_state.skip_left != C_SKIP_NONE) begin
            if (b[7]) begin
                mid.skip_left = i_state.skip_left - 3'd1;
            end else begin
                mid.skip_left = C_SKIP_NONE;
                do_start      = 1'b1;
            end
        end else if (i_state.held_count == C_HELD_NONE) begin
            do_start = 1'b1;
        end else if (!cont) begin
            // broken sequence: replace it, retake this byte as a lead
            mid.held_lead   = 8'h00;
            mid.held_second = 8'h00;
            mid.held_count  = C_HELD_NONE;
            pre_v           = 1'b1;
            do_start        = 1'b1;
        end else if (i_state.held_lead[7:4] != 4'hE) begin
            pre_v = 1'b1;
            if (i_state.held_lead[7:1] != 7'b1100000) begin
                pre_cu  = {5'd0, i_state.held_lead[4:0], b[5:0]};
                pre_rep = 1'b0;
            end
            mid.held_lead   = 8'h00;
            mid.held_second = 8'h00;
            mid.held_count  = C_HELD_NONE;
        end else if (i_state.held_count == C_HELD_LEAD) begin
            mid.held_second = b;
            mid.held_count  = C_HELD_TWO;
        end else begin
            pre_v = 1'b1;
            if (!(surrogate || overlong)) begin
                pre_cu  = {i_state.held_lead[3:0], i_state.held_second[5:0], b[5:0]};
                pre_rep = 1'b0;
            end
            mid.held_lead   = 8'h00;
            mid.held_second = 8'h00;
            mid.held_count  = C_HELD_NONE;
        end

        if (do_start) begin
            if (!b[7]) begin
                st_v   = 1'b1;
                st_cu  = {8'd0, b};
                st_rep = 1'b0;
            end else if (b[7:6] == 2'b10) begin
                st_v = 1'b1;
            end else if (b[7:4] != 4'hF) begin
                mid.held_lead   = b;
                mid.held_second = 8'h00;
                mid.held_count  = C_HELD_LEAD;
            end else begin
                st_v = 1'b1;
                if (!b[3]) begin
                    mid.skip_left = C_SKIP_F0;
                end else if (!b[2]) begin
                    mid.skip_left = C_SKIP_F8;
                end else if (!b[1]) begin
                    mid.skip_left = C_SKIP_FC;
                end
            end
        end

        // final byte: flush a truncated sequence and drop everything
        fin_v   = i_item.final_byte && (mid.held_count != C_HELD_NONE);
        o_state = mid;
        if (i_item.final_byte) begin
            o_state = '0;
        end
    end

    // a start that emits leaves nothing held, so at most two words survive
    always_comb begin
        r0 = '0;
        r1 = '0;
        if (pre_v) begin
            r0.code_unit = pre_cu;
            r0.replaced  = pre_rep;
        end else if (st_v) begin
            r0.code_unit = st_cu;
            r0.replaced  = st_rep;
        end else begin
            r0.code_unit = C_REPL;
            r0.replaced  = 1'b1;
        end
        if (pre_v && st_v) begin
            r1.code_unit = st_cu;
            r1.replaced  = st_rep;
        end else begin
            r1.code_unit = C_REPL;
            r1.replaced  = 1'b1;
        end

        num = {1'b0, pre_v} + {1'b0, st_v} + {1'b0, fin_v};

        if (num == 2'd2) begin
            r1.run_end     = 1'b1;
            r1.string_done = i_item.final_byte;
        end else begin
            r0.run_end     = 1'b1;
            r0.string_done = i_item.final_byte;
        end

        o_step.num  = num;
        o_step.res0 = r0;
        o_step.res1 = r1;
    end

endmodule

`default_nettype wire

FILE: sv/u8d_outq.sv
// ============================================================================
// u8d_outq
// Two-entry result queue: up to two words in per cycle, one out if not stalled.
// ============================================================================
`default_nettype none

module u8d_outq
    import u8d_pkg::*;
(
    input  var logic       i_clk,
    input  var logic       i_rst_n,
    input  var logic [1:0] i_push_num,
    input  var t_res       i_push0,
    input  var t_res       i_push1,
    output var logic [1:0] o_count,
    output var logic       o_out_valid,
    input  var logic       i_out_stall,
    output var t_res       o_out_data
);

    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_res       r_e0;
    t_res       r_e1;
    t_res       n_e0;
    t_res       n_e1;
    logic       pop;
    logic [1:0] cnt_after;

    assign pop       = (r_cnt != 2'd0) && !i_out_stall;
    assign cnt_after = r_cnt - {1'b0, pop};

    // caller guarantees count plus pushes never exceeds two
    always_comb begin
        n_e0 = pop ? r_e1 : r_e0;
        n_e1 = r_e1;
        if (cnt_after == 2'd0) begin
            n_e0 = i_push0;
            n_e1 = i_push1;
        end else if (cnt_after == 2'd1) begin
            n_e1 = i_push0;
        end
        n_cnt = cnt_after + i_push_num;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_e0 <= n_e0;
        r_e1 <= n_e1;
    end

    assign o_count     = r_cnt;
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_data  = r_e0;

`ifndef NO_ASSERTIONS
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result queue overfilled");

    a_done_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.string_done) |-> o_out_data.run_end)
        else $error("string_done without run_end");
`endif

endmodule

`default_nettype wire

FILE: sv/utf8_to_ucs2_stream_decoder.sv
// ============================================================================
// utf8_to_ucs2_stream_decoder
// UTF-8 byte stream to 16-bit code unit decoder with '_' replacement.
// ============================================================================
// Accepts one byte per cycle and, with the output side free, sustains one
// byte per cycle while each byte gives at most one word. A byte is held in
// the input register while it is decoded, and its words are registered in
// the result queue, whose head drives the output. The rate is set by the
// one-result-per-cycle output port behind a two-entry result queue. The
// input stalls whenever the queue, counted before this cycle's output pop,
// cannot absorb the words of the byte held in the input register. A byte
// that yields two words (a broken sequence) therefore stalls the input,
// first for itself and then for the byte behind it, and leaves a one-cycle
// gap on the output. A queue left holding two words by an output stall
// stalls the next byte that gives a word until an output pop frees a slot.
// Bytes that are held as part of a sequence or swallowed after an F0..FD
// lead give no word.
`default_nettype none

module utf8_to_ucs2_stream_decoder
    import u8d_pkg::*;
(
    input  var logic i_clk,
    input  var logic i_rst_n,
    input  var logic i_in_valid,
    output var logic o_in_stall,
    input  var t_in  i_in_data,
    output var logic o_out_valid,
    input  var logic i_out_stall,
    output var t_res o_out_data
);

    logic       r_in_valid;
    t_in        r_in;
    t_state     r_state;
    t_state     dec_state;
    t_step      step;
    logic [1:0] q_count;
    logic [2:0] q_need;
    logic       move;
    logic       accept;
    logic [1:0] push_num;

    u8d_decode u_decode (
        .i_state (r_state),
        .i_item  (r_in),
        .o_state (dec_state),
        .o_step  (step)
    );

    // advance the held byte only when its words all fit in the queue
    assign q_need   = {1'b0, q_count} + {1'b0, step.num};
    assign move     = r_in_valid && (q_need <= 3'd2);
    assign push_num = move ? step.num : 2'd0;

    assign o_in_stall = r_in_valid && !move;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (move) begin
                r_in_valid <= 1'b0;
            end
            if (move) begin
                r_state <= dec_state;
            end
        end
        if (accept) begin
            r_in <= i_in_data;
        end
    end

    u8d_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_num  (push_num),
        .i_push0     (step.res0),
        .i_push1     (step.res1),
        .o_count     (q_count),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

`ifndef NO_ASSERTIONS
    a_skip_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.skip_left != C_SKIP_NONE) |-> (r_state.held_count == C_HELD_NONE))
        else $error("swallowing while a sequence is held");

    a_two_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.held_count == C_HELD_TWO) |-> (r_state.held_lead[7:4] == 4'hE))
        else $error("second byte held for a non three byte lead");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && r_in.final_byte) |=> (r_state == '0))
        else $error("state not cleared after final byte");

    a_held_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.held_count != 2'd3)
        else $error("held count out of range");
`endif

endmodule

`default_nettype wire
